[design/drem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge package
// Shared widths, register indexes and payload types of the run extractor.
// ----------------------------------------------------------------------------
package drem_pkg;

    localparam int X_W      = 12;  // pixel x
    localparam int END_W    = 13;  // run end x, may be area end
    localparam int LINE_W   = 10;  // zero-based input line
    localparam int RLINE_W  = 11;  // one-based result line
    localparam int HOLD_W   = 4;
    localparam int GAP_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Result queue depth; two slots are kept free for a burst of two.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [END_W-1:0]  AREA_END_RST   = '0;
    localparam logic [HOLD_W-1:0] HOLD_COUNT_RST = HOLD_W'(5);
    localparam logic [GAP_W-1:0]  MERGE_GAP_RST  = GAP_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREA_END   = 2'd0,
        CFG_HOLD_COUNT = 2'd1,
        CFG_MERGE_GAP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [END_W-1:0]  area_end;
        logic [HOLD_W-1:0] hold_count;
        logic [GAP_W-1:0]  merge_gap;
    } t_cfg;

    typedef struct packed {
        logic              marked;
        logic [X_W-1:0]    pixel_x;
        logic [LINE_W-1:0] line_index;
        logic              line_last;
    } t_pix;

    typedef struct packed {
        logic [X_W-1:0]     run_start_x;
        logic [END_W-1:0]   run_end_x;
        logic [RLINE_W-1:0] run_line;
        logic               last_of_burst;
    } t_run;

    // Results produced by one processed item
    typedef struct packed {
        logic [1:0] cnt;
        t_run       r0;
        t_run       r1;
    } t_push;

endpackage

[design/drem_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge channel interfaces
// Pixel input channel, run result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface drem_in_if;
    import drem_pkg::*;
    logic              valid;
    logic              ready;
    logic              marked;
    logic [X_W-1:0]    pixel_x;
    logic [LINE_W-1:0] line_index;
    logic              line_last;

    modport source (output valid, marked, pixel_x, line_index, line_last, input ready);
    modport sink   (input valid, marked, pixel_x, line_index, line_last, output ready);
endinterface

interface drem_out_if;
    import drem_pkg::*;
    logic               valid;
    logic               ready;
    logic [X_W-1:0]     run_start_x;
    logic [END_W-1:0]   run_end_x;
    logic [RLINE_W-1:0] run_line;
    logic               last_of_burst;

    modport source (output valid, run_start_x, run_end_x, run_line, last_of_burst,
                    input ready);
    modport sink   (input valid, run_start_x, run_end_x, run_line, last_of_burst,
                    output ready);
endinterface

interface drem_cfg_if;
    import drem_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/drem_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge configuration registers
// Holds area end, hold count and merge gap; writes are taken every cycle.
// ----------------------------------------------------------------------------
module drem_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    drem_cfg_if.sink         i_cfg,
    output drem_pkg::t_cfg   o_cfg
);
    import drem_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register write decode; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_end   <= AREA_END_RST;
            r_cfg.hold_count <= HOLD_COUNT_RST;
            r_cfg.merge_gap  <= MERGE_GAP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_AREA_END:   r_cfg.area_end   <= i_cfg.data[END_W-1:0];
                CFG_HOLD_COUNT: r_cfg.hold_count <= i_cfg.data[HOLD_W-1:0];
                CFG_MERGE_GAP:  r_cfg.merge_gap  <= i_cfg.data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[design/drem_run_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge core
// Input register, hold counter, open run and pending run; one item a cycle while the queue has room.
// ----------------------------------------------------------------------------
module drem_run_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    drem_in_if.sink          i_in,
    input  drem_pkg::t_cfg   i_cfg,
    input  logic             i_room,
    output drem_pkg::t_push  o_push
);
    import drem_pkg::*;

    // Input register
    logic r_vld;
    t_pix r_pix;
    logic adv;

    // Run state
    logic [HOLD_W-1:0]  r_hold,  n_hold;
    logic [X_W-1:0]     r_ostart, n_ostart;
    logic [RLINE_W-1:0] r_oline, n_oline;
    logic               r_pv,    n_pv;
    logic [X_W-1:0]     r_pstart, n_pstart;
    logic [END_W-1:0]   r_pend,  n_pend;
    logic [RLINE_W-1:0] r_pline, n_pline;

    logic               closed;
    logic [X_W-1:0]     cs;
    logic [END_W-1:0]   ce;
    logic [RLINE_W-1:0] cl;
    logic [END_W:0]     reach;
    t_push              push;

    assign adv        = r_vld && i_room;
    assign i_in.ready = !r_vld || i_room;
    assign o_push     = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_vld <= 1'b1;
        end else if (adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_pix.marked     <= i_in.marked;
            r_pix.pixel_x    <= i_in.pixel_x;
            r_pix.line_index <= i_in.line_index;
            r_pix.line_last  <= i_in.line_last;
        end
    end

    // Run tracking: open, count down, close, merge, flush
    always_comb begin
        n_hold   = r_hold;
        n_ostart = r_ostart;
        n_oline  = r_oline;
        n_pv     = r_pv;
        n_pstart = r_pstart;
        n_pend   = r_pend;
        n_pline  = r_pline;
        closed   = 1'b0;
        cs       = r_ostart;
        ce       = '0;
        cl       = r_oline;
        push     = '0;

        if (r_pix.marked) begin
            if (r_hold == '0) begin
                n_hold   = i_cfg.hold_count;
                n_ostart = r_pix.pixel_x;
                n_oline  = {1'b0, r_pix.line_index} + RLINE_W'(1);
            end
        end else if (r_hold != '0) begin
            n_hold = r_hold - HOLD_W'(1);
            if (r_hold == HOLD_W'(1)) begin
                closed = 1'b1;
                ce     = (r_pix.pixel_x == '0) ? '0
                                               : {1'b0, r_pix.pixel_x} - END_W'(1);
            end
        end

        // Line end closes a still open run at the area end
        if (r_pix.line_last && n_hold != '0) begin
            n_hold = '0;
            closed = 1'b1;
            cs     = n_ostart;
            ce     = i_cfg.area_end;
            cl     = n_oline;
        end

        reach = {1'b0, r_pend} + {2'b00, i_cfg.merge_gap};

        if (closed) begin
            if (r_pv && r_pline == cl && reach > {2'b00, cs}) begin
                n_pend = ce;
            end else begin
                if (r_pv) begin
                    push.r0.run_start_x = r_pstart;
                    push.r0.run_end_x   = r_pend;
                    push.r0.run_line    = r_pline;
                    push.cnt            = 2'd1;
                end
                n_pv     = 1'b1;
                n_pstart = cs;
                n_pend   = ce;
                n_pline  = cl;
            end
        end

        // Flush the pending run at line end
        if (r_pix.line_last && n_pv) begin
            if (push.cnt == 2'd0) begin
                push.r0.run_start_x = n_pstart;
                push.r0.run_end_x   = n_pend;
                push.r0.run_line    = n_pline;
            end else begin
                push.r1.run_start_x = n_pstart;
                push.r1.run_end_x   = n_pend;
                push.r1.run_line    = n_pline;
            end
            push.cnt = push.cnt + 2'd1;
            n_pv     = 1'b0;
        end

        // Mark the final result of the burst
        if (push.cnt == 2'd1) begin
            push.r0.last_of_burst = 1'b1;
        end else if (push.cnt == 2'd2) begin
            push.r1.last_of_burst = 1'b1;
        end

        if (!adv) begin
            push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_ostart <= '0;
            r_oline  <= '0;
            r_pv     <= 1'b0;
            r_pstart <= '0;
            r_pend   <= '0;
            r_pline  <= '0;
        end else if (adv) begin
            r_hold   <= n_hold;
            r_ostart <= n_ostart;
            r_oline  <= n_oline;
            r_pv     <= n_pv;
            r_pstart <= n_pstart;
            r_pend   <= n_pend;
            r_pline  <= n_pline;
        end
    end

`ifndef SYNTH
    // Line end leaves no open and no pending run
    a_line_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_pix.line_last |=> r_hold == '0 && !r_pv)
        else $error("run state not cleared at line end");

    // Results only go out when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd0 |-> i_room && r_vld)
        else $error("results pushed without room");

    // Two results in one burst only at line end
    a_two_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt == 2'd2 |-> r_pix.line_last)
        else $error("two results without line end");

    // Held item is not lost while the queue is full
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_room |=> r_vld)
        else $error("stalled item dropped");
`endif

endmodule

[design/drem_out_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge result queue
// Small queue taking up to two results a cycle and handing out one.
// ----------------------------------------------------------------------------
module drem_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  drem_pkg::t_push  i_push,
    output logic             o_room,
    drem_out_if.source       o_out
);
    import drem_pkg::*;

    t_run                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;
    t_run                  head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_room = r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign head   = r_mem[r_rp];

    assign o_out.valid         = r_cnt != '0;
    assign o_out.run_start_x   = head.run_start_x;
    assign o_out.run_end_x     = head.run_end_x;
    assign o_out.run_line      = head.run_line;
    assign o_out.last_of_burst = head.last_of_burst;

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_push.r1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_PTR_W'(i_push.cnt);
            r_rp  <= r_rp + FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push.cnt) - FIFO_CNT_W'(pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> r_wp == r_rp)
        else $error("pointers disagree with empty count");
`endif

endmodule

[design/dropout_run_extract_merge_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dropout run extract/merge top level
// Finds dropout runs in a per-pixel mark stream and merges close runs.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : one pixel item a cycle (mark, x, line, last-pixel flag).
//   o_out : dropout runs (start x, end x, one-based line); last_of_burst
//           marks the final result caused by one pixel item.
//   i_cfg : register writes (area end, hold count, merge gap), always
//           ready; write only while no item is in flight.
// Timing:
//   An accepted item is held in the input register, processed from there
//   into the result queue, and its results are offered on o_out from it.
//   One item per cycle is sustained while the queue has room; an item
//   causing two results is absorbed by a four-entry result queue.
// Stalls:
//   The processing stage waits while fewer than two queue slots are
//   free, and i_in.ready drops once that stage holds a waiting item.
// Reset:
//   Synchronous, active low; clears run state and the queue and loads
//   area end 0, hold count 5, merge gap 50.
// ----------------------------------------------------------------------------
module dropout_run_extract_merge_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drem_in_if.sink     i_in,
    drem_out_if.source  o_out,
    drem_cfg_if.sink    i_cfg
);
    import drem_pkg::*;

    t_cfg  cfg;
    t_push push;
    logic  room;

    drem_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    drem_run_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    drem_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
